// ===== sv/ptft_pkg.sv =====
// Shared types and constants for the FIFO page-replacement translator.
// Holds the item structs, configuration fields, status and register codes.
// No dependencies; every other file but ptft_ram imports this package.
package ptft_pkg;

  // Field widths fixed by the item formats
  localparam int PAGE_W       = 10;
  localparam int OFFSET_W     = 22;
  localparam int STATUS_W     = 3;
  localparam int FRAME_W      = 6;
  localparam int CNT_W        = 32;
  localparam int NUM_PAGES_W  = 11;
  localparam int NUM_FRAMES_W = 7;
  localparam int OFF_LIMIT_W  = 23;

  // Default sizes of the two tables
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int MAX_FRAMES_DEF = 64;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_PAGES    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_FRAMES   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_LIMIT = 2'd2;

  // Register reset values
  localparam logic [NUM_PAGES_W-1:0]  NUM_PAGES_RST    = 11'd1024;
  localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST   = 7'd64;
  localparam logic [OFF_LIMIT_W-1:0]  OFFSET_LIMIT_RST = 23'd2048;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT_BAD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOAD_FREE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_EVICT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAULT_BAD  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_PAGE   = 3'd5;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_number;
    logic [OFFSET_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_number;
    logic [OFFSET_W-1:0] offset_out;
    logic [PAGE_W-1:0]   evicted_page;
    logic [CNT_W-1:0]    fault_count;
    logic [CNT_W-1:0]    request_count;
  } out_item_t;

  typedef struct packed {
    logic [NUM_PAGES_W-1:0]  num_pages;
    logic [NUM_FRAMES_W-1:0] num_frames;
    logic [OFF_LIMIT_W-1:0]  offset_limit;
  } cfg_regs_t;

endpackage

// ===== sv/ptft_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. Uses no package items.
module ptft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ptft_cfg.sv =====
// APB-style configuration registers: page count, frame count, offset limit.
// Depends on ptft_pkg for register codes, widths and reset values.
module ptft_cfg import ptft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t              regs_r, regs_nxt;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_xfer;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_xfer    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Decode the write transfer
  always_comb begin
    regs_nxt = regs_r;
    if (wr_xfer) begin
      unique case (idx)
        REG_NUM_PAGES:    regs_nxt.num_pages    = cfg_pwdata[NUM_PAGES_W-1:0];
        REG_NUM_FRAMES:   regs_nxt.num_frames   = cfg_pwdata[NUM_FRAMES_W-1:0];
        REG_OFFSET_LIMIT: regs_nxt.offset_limit = cfg_pwdata[OFF_LIMIT_W-1:0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_NUM_PAGES:    cfg_prdata = CFG_DATA_W'(regs_r.num_pages);
      REG_NUM_FRAMES:   cfg_prdata = CFG_DATA_W'(regs_r.num_frames);
      REG_OFFSET_LIMIT: cfg_prdata = CFG_DATA_W'(regs_r.offset_limit);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.num_pages    <= NUM_PAGES_RST;
      regs_r.num_frames   <= NUM_FRAMES_RST;
      regs_r.offset_limit <= OFFSET_LIMIT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

// ===== sv/ptft_engine.sv =====
// Translation engine: sequencer around the page table and frame table RAMs.
// Depends on ptft_pkg and ptft_ram; holds victim pointer, fill count, counters.
module ptft_engine import ptft_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PAW = $clog2(MAX_PAGES);
  localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int PTW = FAW + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_EVICT = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [PAW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [FAW-1:0]  vp_r, vp_nxt;
  logic [CW-1:0]   filled_r, filled_nxt;
  logic [CNT_W-1:0] faults_r, faults_nxt;
  logic [CNT_W-1:0] reqs_r, reqs_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  in_item_t        item_r;
  logic [FAW-1:0]  vict_r;
  logic [PAW-1:0]  old_r, old_nxt;

  // Memory ports
  logic            pt_we, pt_re;
  logic [PAW-1:0]  pt_waddr, pt_raddr;
  logic [PTW-1:0]  pt_wdata, pt_rdata;
  logic            ft_we, ft_re;
  logic [FAW-1:0]  ft_waddr, ft_raddr;
  logic [PAW-1:0]  ft_wdata, ft_rdata;

  // Decode helpers
  logic [CW-1:0]   nf;
  logic [FAW-1:0]  v_sel;
  logic            accept, look_go;
  logic            bad_page, pt_hit, in_bounds, frame_used;
  logic [PAW-1:0]  item_page;
  logic [FAW-1:0]  vict_inc;

  // Page table: {valid, frame}, cleared by a sweep after reset
  ptft_ram #(.WIDTH(PTW), .DEPTH(MAX_PAGES)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Frame table: page held by each frame; entries at or above the fill count are unused
  ptft_ram #(.WIDTH(PAW), .DEPTH(MAX_FRAMES)) u_ft_ram (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .re    (ft_re),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  // Clamp the frame count to 1..MAX_FRAMES and pick the victim frame
  always_comb begin
    if (cfg.num_frames == '0) begin
      nf = CW'(1);
    end else if (32'(cfg.num_frames) > 32'(MAX_FRAMES)) begin
      nf = CW'(MAX_FRAMES);
    end else begin
      nf = CW'(cfg.num_frames);
    end
    v_sel = (32'(vp_r) >= 32'(nf)) ? '0 : vp_r;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign look_go    = (state_r == S_LOOK) & (~out_valid_r | out_ready);
  assign item_page  = PAW'(item_r.page_number);
  assign bad_page   = (32'(item_r.page_number) >= 32'(cfg.num_pages)) ||
                      (32'(item_r.page_number) >= 32'(MAX_PAGES));
  assign pt_hit     = pt_rdata[PTW-1];
  assign in_bounds  = OFF_LIMIT_W'(item_r.offset) < cfg.offset_limit;
  // Frames are filled in order from zero, so the fill count marks occupancy
  assign frame_used = 32'(vict_r) < 32'(filled_r);
  assign vict_inc   = (32'(vict_r) + 32'd1 == 32'(nf)) ? '0 : FAW'(32'(vict_r) + 32'd1);

  // Sequencer: clear the page table after reset, read on accept, decide and write back, then unmap an evicted page
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    vp_nxt        = vp_r;
    filled_nxt    = filled_r;
    faults_nxt    = faults_r;
    reqs_nxt      = reqs_r;
    old_nxt       = old_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    pt_we         = 1'b0;
    pt_waddr      = item_page;
    pt_wdata      = '0;
    pt_re         = 1'b0;
    pt_raddr      = PAW'(in_data.page_number);
    ft_we         = 1'b0;
    ft_waddr      = vict_r;
    ft_wdata      = item_page;
    ft_re         = 1'b0;
    ft_raddr      = v_sel;

    unique case (state_r)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_addr_r;
        if (clr_addr_r == PAW'(MAX_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pt_re     = 1'b1;
          ft_re     = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_go) begin
          state_nxt             = S_IDLE;
          reqs_nxt              = (reqs_r == '1) ? reqs_r : reqs_r + 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.frame_number  = '0;
          out_nxt.offset_out    = item_r.offset;
          out_nxt.evicted_page  = '0;
          if (bad_page) begin
            out_nxt.status = ST_BAD_PAGE;
          end else if (pt_hit) begin
            out_nxt.frame_number = FRAME_W'(pt_rdata[FAW-1:0]);
            out_nxt.status       = in_bounds ? ST_HIT_OK : ST_HIT_BAD;
          end else begin
            faults_nxt = (faults_r == '1) ? faults_r : faults_r + 1'b1;
            if (!in_bounds) begin
              out_nxt.status = ST_FAULT_BAD;
            end else begin
              // Load the page into the victim frame
              pt_we                = 1'b1;
              pt_waddr             = item_page;
              pt_wdata             = {1'b1, vict_r};
              ft_we                = 1'b1;
              vp_nxt               = vict_inc;
              out_nxt.frame_number = FRAME_W'(vict_r);
              if (frame_used) begin
                out_nxt.status       = ST_LOAD_EVICT;
                out_nxt.evicted_page = PAGE_W'(ft_rdata);
                if (ft_rdata != item_page) begin
                  old_nxt   = ft_rdata;
                  state_nxt = S_EVICT;
                end
              end else begin
                out_nxt.status = ST_LOAD_FREE;
                if (32'(filled_r) < 32'(MAX_FRAMES)) begin
                  filled_nxt = filled_r + 1'b1;
                end
              end
            end
          end
          // Report the counters as they stand after this access
          out_nxt.fault_count   = faults_nxt;
          out_nxt.request_count = reqs_nxt;
        end
      end
      S_EVICT: begin
        // Unmap the page that lost its frame
        pt_we     = 1'b1;
        pt_waddr  = old_r;
        pt_wdata  = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      vp_r        <= '0;
      filled_r    <= '0;
      faults_r    <= '0;
      reqs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      vp_r        <= vp_nxt;
      filled_r    <= filled_nxt;
      faults_r    <= faults_nxt;
      reqs_r      <= reqs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    old_r <= old_nxt;
    if (accept) begin
      item_r <= in_data;
      vict_r <= v_sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/page_table_fifo_translate_top.sv =====
// Top level of the FIFO page-replacement translator.
// Depends on ptft_pkg, ptft_cfg and ptft_engine (which holds the two RAMs).
//
//   Channel | Ports                      | Carries
//   --------+----------------------------+------------------------------------
//   input   | in_valid/in_ready/in_data  | page number and offset (in_item_t)
//   result  | out_valid/out_ready/out_data | status, frame, counters (out_item_t)
//   config  | cfg_p*                     | num_pages, num_frames, offset_limit
//
// An item's page table and frame table reads are issued in the accept cycle;
// S_LOOK then decides and, on a load, writes both back. A load that evicts
// a page also passes through S_EVICT, since the page table's single write
// port then also unmaps the old page. After reset a clearing pass writes
// every page table entry, one a cycle, with in_ready low; configuration
// writes are taken throughout. One result waits in the output register;
// while it stalls one more item is accepted and then holds in S_LOOK, with
// in_ready low, until the register frees.
module page_table_fifo_translate_top import ptft_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_regs_t cfg;

  // Configuration registers
  ptft_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Translation engine
  ptft_engine #(
    .MAX_PAGES  (MAX_PAGES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ptft_checker.sv =====
// Port-level checks for the translator, bound to the top level below.
// Depends on ptft_pkg for the item types and status codes.
module ptft_checker import ptft_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted item keeps the input closed for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after a transfer");

  // Only an eviction reports an evicted page
  a_evict_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_LOAD_EVICT) |-> out_data.evicted_page == '0)
    else $error("evicted page reported without eviction");

  // Every fault outcome has been counted, and so has its request
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_LOAD_FREE || out_data.status == ST_LOAD_EVICT ||
                  out_data.status == ST_FAULT_BAD)
    |-> out_data.fault_count != '0 && out_data.request_count != '0)
    else $error("fault result with zero counters");

endmodule

bind page_table_fifo_translate_top ptft_checker u_ptft_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for page_table_fifo_translate_top.
// Drives accesses and config writes, predicts each translation and compares.
// Depends on ptft_pkg and the RTL under sv/.
module tb_top;
  import ptft_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Stimulus and expectation stores
  in_item_t  pending_accesses[$];
  out_item_t expected_translations[$];

  idle_mode_t  idle_mode = IDLE_NONE;
  bit          long_stall_req = 1'b0;
  int unsigned stall_count = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the configuration registers
  logic [NUM_PAGES_W-1:0]  mdl_num_pages;
  logic [NUM_FRAMES_W-1:0] mdl_num_frames;
  logic [OFF_LIMIT_W-1:0]  mdl_offset_limit;

  // Shadow of the translation state
  logic                pt_valid   [MAX_PAGES_DEF];
  logic [FRAME_W-1:0]  pt_frame   [MAX_PAGES_DEF];
  logic                frame_used [MAX_FRAMES_DEF];
  logic [PAGE_W-1:0]   frame_page [MAX_FRAMES_DEF];
  logic [FRAME_W-1:0]  victim;
  logic [CNT_W-1:0]    faults_seen;
  logic [CNT_W-1:0]    requests_total;

  page_table_fifo_translate_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame count as the block uses it: zero acts as one, clamp to the table size
  function automatic int unsigned usable_frames();
    int unsigned nf;
    nf = mdl_num_frames;
    if (nf == 0) nf = 1;
    if (nf > MAX_FRAMES_DEF) nf = MAX_FRAMES_DEF;
    return nf;
  endfunction

  function automatic bit src_gap();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(99) < 67;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit sink_gap();
    case (idle_mode)
      IDLE_SNK:  return $urandom_range(99) < 67;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  // Translate one access and advance the shadow state
  function automatic out_item_t translate_access(in_item_t acc);
    out_item_t         res;
    int unsigned       nf;
    int unsigned       v;
    logic [PAGE_W-1:0] old;
    logic              in_bounds;
    res = '0;
    nf = usable_frames();
    in_bounds = ({1'b0, acc.offset} < mdl_offset_limit);
    if (requests_total != '1) requests_total = requests_total + 1'b1;
    res.offset_out = acc.offset;
    if ({1'b0, acc.page_number} >= mdl_num_pages) begin
      res.status = ST_BAD_PAGE;
    end else if (pt_valid[acc.page_number]) begin
      res.frame_number = pt_frame[acc.page_number];
      res.status = in_bounds ? ST_HIT_OK : ST_HIT_BAD;
    end else begin
      if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
      if (!in_bounds) begin
        res.status = ST_FAULT_BAD;
      end else begin
        // wrap a pointer left beyond a lowered frame count
        v = victim;
        if (v >= nf) v = 0;
        if (frame_used[v]) begin
          old = frame_page[v];
          res.evicted_page = old;
          res.status = ST_LOAD_EVICT;
          // unmap the old page only if it still points here
          if (pt_valid[old] && pt_frame[old] == v) pt_valid[old] = 1'b0;
        end else begin
          res.status = ST_LOAD_FREE;
          frame_used[v] = 1'b1;
        end
        frame_page[v] = acc.page_number;
        pt_valid[acc.page_number] = 1'b1;
        pt_frame[acc.page_number] = FRAME_W'(v);
        res.frame_number = FRAME_W'(v);
        victim = FRAME_W'((v + 1) % nf);
      end
    end
    res.fault_count = faults_seen;
    res.request_count = requests_total;
    return res;
  endfunction

  // Compare a result transfer with the oldest expected translation
  task automatic check_result(out_item_t got);
    out_item_t exp_res;
    bit        bad;
    if (expected_translations.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: st=%0d fr=%0d off=%h ev=%0d flt=%0d req=%0d",
                 $realtime, got.status, got.frame_number, got.offset_out,
                 got.evicted_page, got.fault_count, got.request_count);
    end else begin
      exp_res = expected_translations.pop_front();
      bad = (got.status !== exp_res.status) ||
            (got.frame_number !== exp_res.frame_number) ||
            (got.offset_out !== exp_res.offset_out) ||
            (got.evicted_page !== exp_res.evicted_page) ||
            (got.fault_count !== exp_res.fault_count) ||
            (got.request_count !== exp_res.request_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch expected: st=%0d fr=%0d off=%h ev=%0d flt=%0d req=%0d",
                   $realtime, exp_res.status, exp_res.frame_number, exp_res.offset_out,
                   exp_res.evicted_page, exp_res.fault_count, exp_res.request_count);
          $display("[%0t] mismatch actual:   st=%0d fr=%0d off=%h ev=%0d flt=%0d req=%0d",
                   $realtime, got.status, got.frame_number, got.offset_out,
                   got.evicted_page, got.fault_count, got.request_count);
        end
      end
    end
  endtask

  // Track register writes into the shadow configuration
  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_num_pages    <= NUM_PAGES_RST;
      mdl_num_frames   <= NUM_FRAMES_RST;
      mdl_offset_limit <= OFFSET_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_NUM_PAGES:    mdl_num_pages    <= cfg_pwdata[NUM_PAGES_W-1:0];
        REG_NUM_FRAMES:   mdl_num_frames   <= cfg_pwdata[NUM_FRAMES_W-1:0];
        REG_OFFSET_LIMIT: mdl_offset_limit <= cfg_pwdata[OFF_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Driver: predict on each accepted transfer, hold valid until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < MAX_PAGES_DEF; i++) pt_valid[i] = 1'b0;
      for (int i = 0; i < MAX_FRAMES_DEF; i++) frame_used[i] = 1'b0;
      victim = '0;
      faults_seen = '0;
      requests_total = '0;
    end else begin
      if (in_valid && in_ready) expected_translations.push_back(translate_access(in_data));
      if (!in_valid || in_ready) begin
        if (pending_accesses.size() != 0 && !src_gap()) begin
          in_valid <= 1'b1;
          in_data  <= pending_accesses.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result transfers, stall at random or for one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (long_stall_req && stall_count < LONG_STALL) begin
        stall_count <= stall_count + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !sink_gap();
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("page_table_fifo_translate_top verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int unsigned np, input int unsigned nf, input int unsigned lim);
    cfg_write(REG_NUM_PAGES, np);
    cfg_write(REG_NUM_FRAMES, nf);
    cfg_write(REG_OFFSET_LIMIT, lim);
    @(negedge clk);
  endtask

  // Wait until every access is out and every translation is back, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_translations.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_access(input int unsigned page, input int unsigned off);
    in_item_t acc;
    acc.page_number = PAGE_W'(page);
    acc.offset = OFFSET_W'(off);
    pending_accesses.push_back(acc);
  endtask

  // Mostly a working set a bit larger than the frames, plus wild and bad pages
  task automatic add_random(input int unsigned n);
    in_item_t    acc;
    int unsigned ws;
    int unsigned base;
    int unsigned pick;
    int unsigned lim;
    ws = usable_frames() + usable_frames() / 4 + 2;
    base = (mdl_num_pages > ws) ? $urandom_range(mdl_num_pages - ws) : 0;
    lim = (mdl_offset_limit > (1 << OFFSET_W)) ? (1 << OFFSET_W) : mdl_offset_limit;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 65)
        acc.page_number = PAGE_W'(base + $urandom_range(ws - 1));
      else if (pick < 85 || mdl_num_pages >= MAX_PAGES_DEF)
        acc.page_number = PAGE_W'($urandom);
      else
        acc.page_number = PAGE_W'($urandom_range(MAX_PAGES_DEF - 1, mdl_num_pages));
      if (lim != 0 && $urandom_range(99) < 80)
        acc.offset = OFFSET_W'($urandom_range(lim - 1));
      else
        acc.offset = OFFSET_W'($urandom);
      pending_accesses.push_back(acc);
    end
  endtask

  task automatic run_phase(input int unsigned np, input int unsigned nf, input int unsigned lim,
                           input idle_mode_t mode, input int unsigned n, input bit hold_off);
    wait_idle();
    set_config(np, nf, lim);
    idle_mode = mode;
    if (hold_off) long_stall_req = 1'b1;
    add_random(n);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults: free loads, hit in and out of bounds, fault with a bad offset
    push_access(0, 0);
    push_access(0, 2047);
    push_access(0, 2048);
    push_access(1023, 22'h3FFFFF);
    push_access(1023, 0);
    push_access(1023, 22'h3FFFFF);

    // Two frames: bad page, pointer wrap, FIFO evictions
    wait_idle();
    set_config(1000, 2, 23'h7FFFFF);
    push_access(1000, 0);
    push_access(999, 22'h3FFFFF);
    push_access(0, 1);
    push_access(1023, 2);
    push_access(0, 3);

    // Zero frames act as one; zero limit puts every offset out of bounds
    wait_idle();
    set_config(2047, 0, 0);
    push_access(5, 0);
    push_access(0, 0);
    wait_idle();
    cfg_write(REG_OFFSET_LIMIT, 1);
    @(negedge clk);
    push_access(5, 0);
    push_access(6, 0);

    // Frame count above the table acts as the table size; one page in use
    wait_idle();
    set_config(1, 127, 1);
    push_access(1, 0);
    push_access(0, 0);
    push_access(6, 0);

    // Random phases across settings and idling patterns
    run_phase(1024, 64, 2048, IDLE_NONE, 200, 1'b0);
    run_phase(300, 8, 23'h7FFFFF, IDLE_SRC, 200, 1'b0);
    run_phase(2047, 1, 1, IDLE_SNK, 200, 1'b0);
    run_phase(1, 127, 23'h400000, IDLE_BOTH, 100, 1'b0);
    run_phase(0, 3, 100, IDLE_NONE, 40, 1'b0);
    run_phase(512, 0, 0, IDLE_SRC, 60, 1'b0);
    run_phase(700, 16, 4096, IDLE_BOTH, 250, 1'b1);
    run_phase(1024, 64, 2048, IDLE_SNK, 200, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_translations.size() == 0)
      $display("page_table_fifo_translate_top verification clean");
    else
      $display("page_table_fifo_translate_top verification failed");
    $finish;
  end

endmodule

// ===== page_table_fifo_translate_top.f =====
sv/ptft_pkg.sv
sv/ptft_ram.sv
sv/ptft_cfg.sv
sv/ptft_engine.sv
sv/page_table_fifo_translate_top.sv
sv/ptft_checker.sv
dv/tb_top.sv
